/* design/bounded_deque_with_search_top_macros.svh */
// ============================================================================
// Assertion macros for the bounded deque with search
// Concurrent check wrappers; they compile to nothing when SYNTH is defined.
// ============================================================================
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define BDWS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");
// next-cycle implication
`define BDWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");
`else
`define BDWS_ASSERT_NOW(label, clk, rst, ante, cons)
`define BDWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/bdws_pkg.sv */
// ============================================================================
// Bounded deque with search - shared definitions
// Capacity, field widths, action and status codes and the request types.
// ============================================================================
package bdws_pkg;

   // ring size and derived widths
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 6;

   // action codes
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [2:0] ACT_POP_BACK   = 3'd3;
   localparam logic [2:0] ACT_SEARCH     = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             found;
      logic [POS_W-1:0] position;
   } rsp_type;

endpackage

/* design/bounded_deque_with_search_top.sv */
// ============================================================================
// Bounded deque with search
// Ring-buffer double-ended queue of signed 32-bit values with linear search.
// ============================================================================
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  req_data   (action, value)
//  rsp_      out        rsp_valid / rsp_stall  rsp_data   (status, found, position)
//
//  Push, pop and unused actions, and a search of an empty queue, answer from
//  the idle state. A search reads, then compares, each entry: the single read port
//  of the entry store and the one comparator are stepped by the sequencer.
//  A request is still taken while a finished response waits; the next one
//  then waits until that response has gone. Synchronous reset empties the
//  queue at once; the entry store is not cleared.
// ============================================================================
`include "bounded_deque_with_search_top_macros.svh"

module bounded_deque_with_search_top
   import bdws_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_WAIT
   } state_type;

   // ring index: base + offset, wrapped once
   function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         sum = sum - (IDX_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic signed [31:0] key_ff, key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   rsp_type            hold_ff, hold_in;

   logic [31:0]        entry_store_ff [CAPACITY];
   logic [31:0]        rd_data_ff;

   logic               req_accept;
   logic               rsp_free;
   logic               is_full, is_empty;
   logic [IDX_W-1:0]   ring_off, ring_out;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic               res_go;
   rsp_type            res;
   logic               last_k;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign last_k     = ((CNT_W'(k_ff) + CNT_W'(1)) == count_ff);

   // shared ring adder: offset chosen by what the sequencer is doing
   always_comb begin
      ring_off = k_ff;
      if (state_ff == S_IDLE) begin
         if (req_data.action == ACT_PUSH_BACK) begin
            ring_off = IDX_W'(count_ff);
         end else begin
            ring_off = IDX_W'(1);
         end
      end
   end
   assign ring_out = ring_idx(head_ff, ring_off);

   // next-state and result logic
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      key_in       = key_ff;
      hold_in      = hold_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_wa       = ring_out;
      res_go       = 1'b0;
      res          = '{status: ST_OK, found: 1'b0, position: '0};

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_go = 1'b1;
               case (req_data.action)
                  ACT_PUSH_FRONT: begin
                     if (is_full) begin
                        res.status = ST_FULL;
                     end else begin
                        head_in  = (head_ff == '0) ? IDX_W'(CAPACITY - 1)
                                                   : head_ff - IDX_W'(1);
                        mem_we   = 1'b1;
                        mem_wa   = head_in;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_PUSH_BACK: begin
                     if (is_full) begin
                        res.status = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (is_empty) begin
                        res.status = ST_EMPTY;
                     end else begin
                        head_in  = ring_out;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_POP_BACK: begin
                     if (is_empty) begin
                        res.status = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_SEARCH: begin
                     if (is_empty) begin
                        res.status = ST_EMPTY;
                     end else begin
                        res_go   = 1'b0;
                        key_in   = req_data.value;
                        k_in     = '0;
                        state_in = S_SEARCH_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH_RD: begin
            state_in = S_SEARCH_CMP;
         end
         S_SEARCH_CMP: begin
            if (rd_data_ff == key_ff) begin
               res_go       = 1'b1;
               res.found    = 1'b1;
               res.position = POS_W'(k_ff);
            end else if (last_k) begin
               res_go = 1'b1;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = S_SEARCH_RD;
            end
         end
         S_WAIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // deliver a finished result, or park it while the output is stalled
      if (res_go) begin
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res;
            state_in     = S_IDLE;
         end else begin
            hold_in  = res;
            state_in = S_WAIT;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   // entry store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store_ff[mem_wa] <= req_data.value;
      end
      rd_data_ff <= entry_store_ff[ring_out];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `BDWS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `BDWS_ASSERT_NOW(a_wait_only_when_busy, clock, reset, state_ff == S_WAIT, rsp_valid_ff)
   `BDWS_ASSERT_NOW(a_search_in_span, clock, reset, state_ff == S_SEARCH_CMP, CNT_W'(k_ff) < count_ff)
   `BDWS_ASSERT_NOW(a_found_is_ok, clock, reset, rsp_valid_ff && rsp_data_ff.found, rsp_data_ff.status == ST_OK)
   `BDWS_ASSERT_NEXT(a_quick_result, clock, reset, req_accept && req_data.action != ACT_SEARCH, (state_ff == S_IDLE && rsp_valid_ff) || state_ff == S_WAIT)

endmodule

/* test/tb.sv */
// ============================================================================
// Testbench for the bounded deque with search
// Drives push, pop, search and unused requests through the valid/stall
// channels and checks every response against a shadow ring with its own head
// index and entry count. Covers directed corner cases, fill and drain to the
// capacity limits, random traffic under several idle and stall mixes, and a
// long receiver hold-off that fills the block and stalls its input.
// ============================================================================
module tb;
   import bdws_pkg::*;

   // allows a full-length search and the response slot to clear
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
   localparam int WAIT_LIMIT   = 50000;

   // random traffic styles
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIX   = 2;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // shadow copy of the deque
   logic signed [31:0] shadow_store [CAPACITY];
   logic [IDX_W-1:0]   shadow_head  = '0;
   logic [CNT_W-1:0]   shadow_count = '0;

   rsp_type pending_rsps [$];
   int      error_count   = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      hold_cycles   = 0;

   bounded_deque_with_search_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ring slot at a given distance from the head
   function automatic int ring_slot(input int offset);
      return (int'(shadow_head) + offset) % CAPACITY;
   endfunction

   // apply one request to the shadow deque and return its response
   function automatic rsp_type deque_apply(input req_type r);
      rsp_type res;
      int      k;
      res = '0;
      res.status = ST_OK;
      case (r.action)
         ACT_PUSH_FRONT: begin
            if (shadow_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               shadow_head = (shadow_head == 0) ? IDX_W'(CAPACITY - 1) : shadow_head - 1'b1;
               shadow_store[shadow_head] = r.value;
               shadow_count = shadow_count + 1'b1;
            end
         end
         ACT_PUSH_BACK: begin
            if (shadow_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               shadow_store[ring_slot(int'(shadow_count))] = r.value;
               shadow_count = shadow_count + 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               shadow_head = IDX_W'(ring_slot(1));
               shadow_count = shadow_count - 1'b1;
            end
         end
         ACT_POP_BACK: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               shadow_count = shadow_count - 1'b1;
            end
         end
         ACT_SEARCH: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               for (k = 0; k < int'(shadow_count); k++) begin
                  if (shadow_store[ring_slot(k)] == r.value) begin
                     res.found = 1'b1;
                     res.position = k[POS_W-1:0];
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // element value: small set for duplicates, extremes, or anything
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 25) return int'($urandom_range(8)) - 4;
      if (r < 35) begin
         case ($urandom_range(3))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // search key: mostly a value held in the deque
   function automatic logic signed [31:0] pick_search_value();
      if (shadow_count != 0 && $urandom_range(99) < 60)
         return shadow_store[ring_slot($urandom_range(int'(shadow_count) - 1))];
      return pick_value();
   endfunction

   // action weighted by traffic style
   function automatic logic [2:0] pick_action(input int mode);
      int r;
      int push_pct;
      r = $urandom_range(99);
      push_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 20 : 50;
      if (r < 3) return 3'($urandom_range(7, 5));
      if (r < 23) return ACT_SEARCH;
      if ($urandom_range(99) < push_pct)
         return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
   endfunction

   // offer one request; called and returns at a falling edge
   task automatic send_request(input logic [2:0] act, input logic signed [31:0] val);
      req_type item;
      item.action = act;
      item.value  = val;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      pending_rsps.push_back(deque_apply(item));
      @(negedge clock);
   endtask

   // send a request with a fitting value for its action
   task automatic send_action(input logic [2:0] act);
      send_request(act, (act == ACT_SEARCH) ? pick_search_value() : pick_value());
   endtask

   // receiver: random stall, or a long hold-off when asked
   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // response checker
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: response with none expected: status=%0d found=%0d position=%0d",
                     $time, rsp_data.status, rsp_data.found, rsp_data.position);
            error_count++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.found !== want.found) begin
               $display("%0t: found expected %0d actual %0d",
                        $time, want.found, rsp_data.found);
               error_count++;
            end
            if (rsp_data.position !== want.position) begin
               $display("%0t: position expected %0d actual %0d",
                        $time, want.position, rsp_data.position);
               error_count++;
            end
         end
      end
   end

   // empty cases, extremes, duplicates and unused codes
   task automatic test_directed();
      send_request(ACT_POP_FRONT, 32'sh0);
      send_request(ACT_POP_BACK, -32'sd1);
      send_request(ACT_SEARCH, 32'sh0);
      send_request(3'd5, 32'sh8000_0000);
      send_request(3'd6, 32'sh7FFF_FFFF);
      send_request(3'd7, -32'sd1);
      send_request(ACT_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_request(ACT_PUSH_BACK, 32'sh8000_0000);
      send_request(ACT_PUSH_FRONT, -32'sd1);
      send_request(ACT_PUSH_BACK, 32'sh0);
      send_request(ACT_SEARCH, 32'sh8000_0000);
      send_request(ACT_SEARCH, -32'sd1);
      send_request(ACT_SEARCH, 32'sh0);
      send_request(ACT_SEARCH, 32'sd12345);
      // duplicate: first match wins, then the later copy after a front pop
      send_request(ACT_PUSH_BACK, -32'sd1);
      send_request(ACT_SEARCH, -32'sd1);
      send_request(ACT_POP_FRONT, 32'sh0);
      send_request(ACT_SEARCH, -32'sd1);
      send_request(3'd5, 32'sh7FFF_FFFF);
      send_request(3'd7, 32'sh8000_0000);
      send_request(ACT_POP_BACK, 32'sh0);
      send_request(ACT_POP_BACK, 32'sh0);
      send_request(ACT_POP_FRONT, 32'sh0);
      send_request(ACT_POP_FRONT, 32'sh0);
      send_request(ACT_SEARCH, -32'sd1);
   endtask

   // fill to capacity, push when full, search both ends, drain past empty
   task automatic test_capacity();
      int i;
      for (i = 0; i < CAPACITY; i++)
         send_action((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT);
      send_action(ACT_PUSH_FRONT);
      send_action(ACT_PUSH_BACK);
      send_request(ACT_SEARCH, shadow_store[ring_slot(0)]);
      send_request(ACT_SEARCH, shadow_store[ring_slot(CAPACITY - 1)]);
      send_action(ACT_SEARCH);
      for (i = 0; i < CAPACITY; i++)
         send_action((i % 2) ? ACT_POP_BACK : ACT_POP_FRONT);
      send_action(ACT_POP_BACK);
      send_action(ACT_POP_FRONT);
   endtask

   // random traffic swinging between filling and draining
   task automatic test_random(input int count);
      int i;
      int mode;
      mode = MODE_FILL;
      for (i = 0; i < count; i++) begin
         if (mode == MODE_FILL && shadow_count == CAPACITY && $urandom_range(99) < 30)
            mode = MODE_DRAIN;
         else if (mode == MODE_DRAIN && shadow_count == 0 && $urandom_range(99) < 30)
            mode = MODE_FILL;
         else if ($urandom_range(99) < 2)
            mode = $urandom_range(MODE_MIX);
         send_action(pick_action(mode));
      end
   endtask

   // receiver holds off while the sender keeps offering requests
   task automatic test_backpressure();
      int i;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_cycles   = 400;
      for (i = 0; i < 60; i++)
         send_action(pick_action(MODE_MIX));
   endtask

   // wait for outstanding responses and report
   task automatic finish_run();
      int i;
      req_valid <= 1'b0;
      for (i = 0; i < WAIT_LIMIT && pending_rsps.size() != 0; i++)
         @(posedge clock);
      if (pending_rsps.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_rsps.size());
         error_count++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   endtask

   // main sequence
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_capacity();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random(400);
      send_idle_pct = 46;
      rsp_stall_pct = 0;
      test_random(400);
      send_idle_pct = 0;
      rsp_stall_pct = 46;
      test_random(400);
      send_idle_pct = 8;
      rsp_stall_pct = 8;
      test_random(400);
      test_backpressure();
      finish_run();
   end

   // run time limit
   initial begin
      #12000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
